>>> hdl/md5_message_digest_unit_defines.svh
// ----------------------------------------------------------------------------
// MD5 digest unit assertion macros
// Concurrent check wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`ifndef SYNTH
// expr must hold at every clock edge out of reset
`define MD5_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// cons must hold in the cycle after ante
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MD5_ASSERT_ALWAYS(label, expr, msg)
`define MD5_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Item types, sequencer states, round constants and helper functions.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        is_last;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        is_last_word;
    } digest_item_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } abcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    localparam abcd_t IV = '{a: 32'h67452301, b: 32'hefcdab89,
                             c: 32'h98badcfe, d: 32'h10325476};

    localparam logic [31:0] PAD_MARKER      = 32'h0000_0080;
    localparam logic [3:0]  LEN_LO_IDX      = 4'd14;
    localparam logic [3:0]  LAST_WORD_IDX   = 4'd15;
    localparam logic [5:0]  LAST_ROUND      = 6'd63;
    localparam logic [1:0]  LAST_DIGEST_IDX = 2'd3;
    localparam logic [2:0]  FULL_BYTES      = 3'd4;

    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a given round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] g;
        r = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = r;
            2'd1:    g = r * 4'd5 + 4'd1;
            2'd2:    g = r * 4'd3 + 4'd5;
            default: g = r * 4'd7;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        return ROT_TAB[{rnd[5:4], rnd[1:0]}];
    endfunction

    // last partial word: keep n bytes, put the 0x80 marker right after them
    function automatic logic [31:0] pad_word(input logic [31:0] data, input logic [1:0] n);
        logic [31:0] w;
        case (n)
            2'd0:    w = PAD_MARKER;
            2'd1:    w = {16'h0000, PAD_MARKER[7:0], data[7:0]};
            2'd2:    w = {8'h00, PAD_MARKER[7:0], data[15:0]};
            default: w = {PAD_MARKER[7:0], data[23:0]};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/md5_chan_if.sv
// ----------------------------------------------------------------------------
// MD5 stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface md5_chan_if #(
    parameter type payload_t = logic [31:0]
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

>>> hdl/md5_round.sv
// ----------------------------------------------------------------------------
// MD5 round
// One MD5 step: round function, constant and message add, rotate, add.
// ----------------------------------------------------------------------------
module md5_round
    import md5_pkg::*;
(
    input  logic [5:0]  rnd,
    input  abcd_t       cur,
    input  logic [31:0] m_word,
    output abcd_t       nxt
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;

    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
            2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
            2'd2:    f = cur.b ^ cur.c ^ cur.d;
            default: f = cur.c ^ (cur.b | ~cur.d);
        endcase
    end

    assign sum      = cur.a + f + SINE_TAB[rnd] + m_word;
    assign rot_wide = {sum, sum} << rot_amount(rnd);

    assign nxt.a = cur.d;
    assign nxt.b = cur.b + rot_wide[63:32];
    assign nxt.c = cur.b;
    assign nxt.d = cur.c;

endmodule

>>> hdl/md5_message_digest_unit.sv
// ----------------------------------------------------------------------------
// MD5 message digest unit
// Streaming MD5 over 32-bit little-endian words, digest out as four words.
// ----------------------------------------------------------------------------
// Usage: feed the message on msg, four bytes per transfer, first byte in
// bits 7:0; the final transfer sets is_last and carries 0 to 4 bytes in
// byte_count (values above 4 count as 4, byte_count is ignored otherwise).
// An empty message is a single last transfer with zero bytes. After the
// final transfer the unit pads, compresses and returns the digest A, B, C, D
// as four transfers on digest, then goes back to the initial vector for the
// next message. Timing: words are taken back to back while the unit is idle;
// the transfer that completes a 16-word block is followed by 64 rounds
// through the single round unit and a chaining update, during which no word
// is taken. After the last transfer the unit writes padding and length
// (spilling into a second block when the length no longer fits), runs one
// or two compressions and loads the four digest words, waiting while digest
// is stalled. msg.ready is high only while the sequencer sits in its idle
// state. The block store is a 16-word memory with a registered read; it needs
// no clearing after reset.
// ----------------------------------------------------------------------------
`include "md5_message_digest_unit_defines.svh"

module md5_message_digest_unit
    import md5_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    md5_chan_if.sink   msg,
    md5_chan_if.source digest
);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t       state_reg,    state_next;
    logic [3:0]   wcnt_reg,     wcnt_next;      // words held in the block store
    logic [5:0]   rnd_reg,      rnd_next;
    abcd_t        abcd_reg,     abcd_next;      // working a,b,c,d
    abcd_t        chain_reg,    chain_next;     // chaining value
    logic [60:0]  bytes_reg,    bytes_next;     // message byte count mod 2^61
    logic         fin_reg,      fin_next;       // last item seen, finishing
    logic         pad_reg,      pad_next;       // lone 0x80 word still owed
    logic         len_reg,      len_next;       // length low word written
    logic [1:0]   emit_idx_reg, emit_idx_next;
    logic         out_valid_reg, out_valid_next;
    digest_item_t out_item_reg,  out_item_next;

    // block store
    logic [31:0]  mem [16];
    logic [31:0]  rd_data_reg;
    logic [3:0]   rd_addr;
    logic         wr_en;
    logic [31:0]  wr_data;

    logic         msg_xfer;
    logic         out_load;
    logic         block_full;
    logic [2:0]   n_sat;
    logic [2:0]   n_add;
    logic [31:0]  len_lo;
    logic [31:0]  len_hi;
    logic [31:0]  emit_word;
    abcd_t        round_out;

    assign msg_xfer   = msg.valid && msg.ready;
    assign block_full = wr_en && (wcnt_reg == LAST_WORD_IDX);
    assign n_sat      = (msg.payload.byte_count > FULL_BYTES) ? FULL_BYTES
                                                              : msg.payload.byte_count;
    assign n_add      = msg.payload.is_last ? n_sat : FULL_BYTES;

    // bit length = bytes * 8, split into two little-endian words
    assign len_lo = {bytes_reg[28:0], 3'b000};
    assign len_hi = bytes_reg[60:29];

    // ------------------------------------------------------------------
    // round unit, shared across all 64 steps of every block
    // ------------------------------------------------------------------
    md5_round u_round (
        .rnd    (rnd_reg),
        .cur    (abcd_reg),
        .m_word (rd_data_reg),
        .nxt    (round_out)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_xfer)
                begin
                    if (wcnt_reg == LAST_WORD_IDX)
                        state_next = ST_ROUND;
                    else if (msg.payload.is_last)
                        state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (wcnt_reg == LAST_WORD_IDX)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (len_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_FILL;
            end
            ST_EMIT:
            begin
                if (out_load && (emit_idx_reg == LAST_DIGEST_IDX))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs: handshakes and block store port controls
    // ------------------------------------------------------------------
    always_comb
    begin
        msg.ready = (state_reg == ST_IDLE);
        out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || digest.ready);
        wr_en     = 1'b0;
        wr_data   = '0;
        // prefetch the word the next round needs; address 0 ahead of round 0
        rd_addr   = (state_reg == ST_ROUND) ? msg_index(rnd_reg + 6'd1) : '0;
        case (state_reg)
            ST_IDLE:
            begin
                wr_en = msg_xfer;
                if (!msg.payload.is_last || (n_sat == FULL_BYTES))
                    wr_data = msg.payload.data_word;
                else
                    wr_data = pad_word(msg.payload.data_word, n_sat[1:0]);
            end
            ST_FILL:
            begin
                wr_en = 1'b1;
                if (pad_reg)
                    wr_data = PAD_MARKER;
                else if (wcnt_reg == LEN_LO_IDX)
                    wr_data = len_lo;
                else if ((wcnt_reg == LAST_WORD_IDX) && len_reg)
                    wr_data = len_hi;
                else
                    wr_data = '0;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_data = '0;
            end
        endcase
    end

    assign digest.valid   = out_valid_reg;
    assign digest.payload = out_item_reg;

    always_comb
    begin
        case (emit_idx_reg)
            2'd0:    emit_word = chain_reg.a;
            2'd1:    emit_word = chain_reg.b;
            2'd2:    emit_word = chain_reg.c;
            default: emit_word = chain_reg.d;
        endcase
    end

    // ------------------------------------------------------------------
    // register next values
    // ------------------------------------------------------------------
    always_comb
    begin
        wcnt_next      = wcnt_reg;
        rnd_next       = rnd_reg;
        abcd_next      = abcd_reg;
        chain_next     = chain_reg;
        bytes_next     = bytes_reg;
        fin_next       = fin_reg;
        pad_next       = pad_reg;
        len_next       = len_reg;
        emit_idx_next  = emit_idx_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !digest.ready;

        if (wr_en)
            wcnt_next = wcnt_reg + 4'd1;

        // 16th word written: load working registers for round 0
        if (block_full)
        begin
            abcd_next = chain_reg;
            rnd_next  = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_xfer)
                begin
                    bytes_next = bytes_reg + {58'd0, n_add};
                    if (msg.payload.is_last)
                    begin
                        fin_next = 1'b1;
                        pad_next = (n_sat == FULL_BYTES);
                    end
                end
            end
            ST_FILL:
            begin
                pad_next = 1'b0;
                if (!pad_reg && (wcnt_reg == LEN_LO_IDX))
                    len_next = 1'b1;
            end
            ST_ROUND:
            begin
                abcd_next = round_out;
                rnd_next  = rnd_reg + 6'd1;
            end
            ST_UPDATE:
            begin
                chain_next.a = chain_reg.a + abcd_reg.a;
                chain_next.b = chain_reg.b + abcd_reg.b;
                chain_next.c = chain_reg.c + abcd_reg.c;
                chain_next.d = chain_reg.d + abcd_reg.d;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.digest_word  = emit_word;
                    out_item_next.word_index   = emit_idx_reg;
                    out_item_next.is_last_word = (emit_idx_reg == LAST_DIGEST_IDX);
                    emit_idx_next              = emit_idx_reg + 2'd1;
                    if (emit_idx_reg == LAST_DIGEST_IDX)
                    begin
                        // message done: back to the initial vector
                        chain_next = IV;
                        bytes_next = '0;
                        fin_next   = 1'b0;
                        len_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                wcnt_next = wcnt_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wcnt_reg      <= '0;
            rnd_reg       <= '0;
            abcd_reg      <= '0;
            chain_reg     <= IV;
            bytes_reg     <= '0;
            fin_reg       <= 1'b0;
            pad_reg       <= 1'b0;
            len_reg       <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wcnt_reg      <= wcnt_next;
            rnd_reg       <= rnd_next;
            abcd_reg      <= abcd_next;
            chain_reg     <= chain_next;
            bytes_reg     <= bytes_next;
            fin_reg       <= fin_next;
            pad_reg       <= pad_next;
            len_reg       <= len_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // block store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wcnt_reg] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `MD5_ASSERT_ALWAYS(a_round_on_full_block, (state_reg != ST_ROUND) || (wcnt_reg == '0), "rounds running on a partial block")
    `MD5_ASSERT_NEXT(a_rounds_end, (state_reg == ST_ROUND) && (rnd_reg == LAST_ROUND), state_reg == ST_UPDATE, "round 63 not followed by update")
    `MD5_ASSERT_NEXT(a_update_to_idle, (state_reg == ST_UPDATE) && !fin_reg, state_reg == ST_IDLE, "mid-message update did not return to idle")
    `MD5_ASSERT_ALWAYS(a_len_when_finishing, !len_reg || fin_reg, "length written outside message end")
    `MD5_ASSERT_ALWAYS(a_pad_when_finishing, !pad_reg || fin_reg, "pad marker owed outside message end")

endmodule

>>> tb/sv/md5_message_digest_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message digest unit testbench
// Streams messages of mixed lengths into the unit and checks every digest
// word against an MD5 predictor kept in the bench, with random gaps on both
// channels.
// ----------------------------------------------------------------------------
module md5_message_digest_unit_test;
    import md5_pkg::*;

    localparam int RUN_LIMIT    = 400000; // cycles before the run is declared hung
    localparam int DRAIN_CYCLES = 200;    // > two compressions plus padding fill
    localparam int RANDOM_ITEMS = 140;

    // MD5 per-round additive constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts, indexed by {stage, round mod 4}
    localparam int ROUND_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam logic [31:0] START_CHAIN [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] MARKER_BYTE = 32'h0000_0080;

    // clock and reset; the declared values hold every input known from time 0
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    md5_chan_if #(.payload_t(msg_item_t))    msg_if ();
    md5_chan_if #(.payload_t(digest_item_t)) digest_if ();

    // bench-side registers behind the unit's inputs
    logic      msg_valid_q   = 1'b0;
    msg_item_t msg_payload_q = '0;
    logic      digest_ready_q = 1'b0;

    assign msg_if.valid    = msg_valid_q;
    assign msg_if.payload  = msg_payload_q;
    assign digest_if.ready = digest_ready_q;

    md5_message_digest_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if.sink),
        .digest (digest_if.source)
    );

    // ------------------------------------------------------------------------
    // Predictor state: chaining words, the 16-word block being filled and the
    // running byte count (61 bits, so the bit length wraps modulo 2^64).
    // ------------------------------------------------------------------------
    logic [31:0]  chain_words [4];
    logic [31:0]  block_words [16];
    int           block_fill;
    logic [60:0]  message_bytes;

    msg_item_t    msg_pending [$];      // items not yet offered to the unit
    digest_item_t digest_expected [$];  // digest words still to come

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle      = 0;
    int send_calm      = 0;
    int recv_idle      = 0;
    int recv_calm      = 0;

    // one full 64-round MD5 compression of block_words into chain_words
    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        int g, s;
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d);
                g = i;
            end
            else if (i < 32)
            begin
                f = (b & d) | (c & ~d);
                g = (5 * i + 1) % 16;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d;
                g = (3 * i + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d);
                g = (7 * i) % 16;
            end
            f = a + f + ROUND_K[i] + block_words[g];
            s = ROUND_SHIFT[(i / 16) * 4 + (i % 4)];
            t = d;
            d = c;
            c = b;
            b = b + ((f << s) | (f >> (32 - s)));
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        block_words[block_fill] = w;
        block_fill++;
        if (block_fill == 16)
        begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 4; i++)
            chain_words[i] = START_CHAIN[i];
        block_fill    = 0;
        message_bytes = '0;
    endfunction

    // update the predictor with one accepted item; a last item queues the digest
    function automatic void absorb_item(input msg_item_t item);
        int           n;
        logic [31:0]  tail;
        logic [63:0]  bit_len;
        digest_item_t dw;
        if (!item.is_last)
        begin
            // byte count is don't-care before the last word
            message_bytes += 61'd4;
            absorb_word(item.data_word);
            return;
        end
        n = (item.byte_count > FULL_BYTES) ? 4 : int'(item.byte_count);
        message_bytes += 61'(n);
        if (n == 4)
        begin
            // full last word: the marker starts a word of its own
            absorb_word(item.data_word);
            tail = MARKER_BYTE;
        end
        else
            tail = (item.data_word & ((32'h1 << (8 * n)) - 32'h1)) | (MARKER_BYTE << (8 * n));
        absorb_word(tail);
        // no room left for the length: zero out and compress an extra block
        if (block_fill > 14)
            while (block_fill != 0)
                absorb_word(32'h0);
        while (block_fill < 14)
        begin
            block_words[block_fill] = 32'h0;
            block_fill++;
        end
        bit_len = {message_bytes, 3'b000};
        block_words[14] = bit_len[31:0];
        block_words[15] = bit_len[63:32];
        compress_block();
        for (int j = 0; j < 4; j++)
        begin
            dw.digest_word  = chain_words[j];
            dw.word_index   = 2'(j);
            dw.is_last_word = (j == 3);
            digest_expected.push_back(dw);
        end
        restart_message();
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic queue_item(input logic [31:0] data, input logic [2:0] nbytes,
                              input logic last);
        msg_item_t item;
        item.data_word  = data;
        item.byte_count = nbytes;
        item.is_last    = last;
        msg_pending.push_back(item);
    endtask

    // one message of body_words full words and a final word with last_bytes;
    // sloppy messages put junk in the byte count of the body words
    task automatic queue_message(input int body_words, input int last_bytes,
                                 input bit sloppy);
        logic [2:0] nb;
        for (int i = 0; i < body_words; i++)
        begin
            nb = (sloppy || $urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7))
                                                         : FULL_BYTES;
            queue_item($urandom, nb, 1'b0);
        end
        queue_item($urandom, 3'(last_bytes), 1'b1);
    endtask

    // Gap length for either side: mostly none or short, now and then long,
    // with occasional stretches of back-to-back transfers.
    function automatic int idle_span(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0d] mismatch: %s: got %h, expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_digest(input digest_item_t got);
        digest_item_t want;
        if (digest_expected.size() == 0)
        begin
            report_mismatch("digest transfer with nothing pending", got.digest_word, 32'h0);
            return;
        end
        want = digest_expected.pop_front();
        if (got.digest_word !== want.digest_word)
            report_mismatch("digest_word", got.digest_word, want.digest_word);
        if (got.word_index !== want.word_index)
            report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
        if (got.is_last_word !== want.is_last_word)
            report_mismatch("is_last_word", 32'(got.is_last_word), 32'(want.is_last_word));
    endtask

    // ------------------------------------------------------------------------
    // Message driver: offers pending items, runs the predictor on each transfer
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid_q   <= 1'b0;
            msg_payload_q <= '0;
            send_idle     <= 0;
        end
        else
        begin
            if (msg_valid_q && msg_if.ready)
                absorb_item(msg_payload_q);
            // hold the item while it waits for ready
            if (!msg_valid_q || msg_if.ready)
            begin
                if (send_idle > 0)
                begin
                    msg_valid_q <= 1'b0;
                    send_idle   <= send_idle - 1;
                end
                else if (msg_pending.size() > 0)
                begin
                    msg_valid_q   <= 1'b1;
                    msg_payload_q <= msg_pending.pop_front();
                    send_idle     <= idle_span(send_calm);
                end
                else
                    msg_valid_q <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Digest monitor: checks each transfer, stalls ready at random
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : digest_side
        int span;
        if (!rst_n)
        begin
            digest_ready_q <= 1'b0;
            recv_idle      <= 0;
        end
        else
        begin
            span = recv_idle;
            if (digest_if.valid && digest_ready_q)
            begin
                check_digest(digest_if.payload);
                span = idle_span(recv_calm);
            end
            else if (recv_idle == 0 && $urandom_range(0, 15) == 0)
                span = idle_span(recv_calm);
            if (span > 0)
            begin
                digest_ready_q <= 1'b0;
                recv_idle      <= span - 1;
            end
            else
            begin
                digest_ready_q <= 1'b1;
                recv_idle      <= 0;
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("md5_message_digest_unit_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int r, body, lastb, directed_items;
        bit sloppy;

        for (int i = 0; i < 16; i++)
            block_words[i] = 32'h0;
        restart_message();

        // directed: empty message, each final byte count with junk above it,
        // count saturation above four, ignored counts on body words
        queue_item(32'h0000_0000, 3'd0, 1'b1);
        queue_item(32'hffff_ffff, 3'd1, 1'b1);
        queue_item(32'hffff_ffff, 3'd2, 1'b1);
        queue_item(32'hffff_ffff, 3'd3, 1'b1);
        queue_item(32'hffff_ffff, 3'd4, 1'b1);
        queue_item(32'h0000_0000, 3'd4, 1'b1);
        queue_item(32'ha5a5_a5a5, 3'd7, 1'b1);
        queue_item(32'h1234_5678, 3'd5, 1'b1);
        queue_item(32'hffff_ffff, 3'd6, 1'b1);
        queue_item(32'hffff_ffff, 3'd0, 1'b0);
        queue_item(32'h0000_0000, 3'd0, 1'b1);
        queue_item(32'h0000_0000, 3'd7, 1'b0);
        queue_item(32'h8000_0001, 3'd3, 1'b1);
        directed_items = msg_pending.size();

        // random messages; lengths cluster around the padding boundary
        // (52..68 bytes) and a few span two or more blocks
        while (msg_pending.size() < directed_items + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                body = $urandom_range(0, 5);
            else if (r < 80)
                body = $urandom_range(13, 16);
            else if (r < 95)
                body = $urandom_range(17, 31);
            else
                body = $urandom_range(32, 40);
            sloppy = ($urandom_range(0, 9) == 0);
            lastb  = sloppy ? $urandom_range(0, 7) : $urandom_range(0, 4);
            queue_message(body, lastb, sloppy);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (msg_pending.size() > 0 || msg_valid_q || digest_expected.size() > 0)
            @(negedge clk);
        // catch any stray digest words after the last expected one
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("md5_message_digest_unit_test passed");
        else
            $display("md5_message_digest_unit_test failed");
        $finish;
    end

endmodule

>>> md5_message_digest_unit.f
+incdir+hdl
hdl/md5_pkg.sv
hdl/md5_chan_if.sv
hdl/md5_round.sv
hdl/md5_message_digest_unit.sv
tb/sv/md5_message_digest_unit_test.sv
